### rtl/core/trwc_pkg.sv
// ----------------------------------------------------------------------------
// trwc_pkg
// Types and constants shared by the TCP receive window checker modules.
// ----------------------------------------------------------------------------
package trwc_pkg;

  localparam int SEQ_W = 32;
  localparam int LEN_W = 17;
  localparam int WIN_W = 31;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [WIN_W-1:0] win_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_WINDOW_SIZE = 1'd0;
  localparam cfg_idx_t REG_START_SEQUENCE = 1'd1;

  typedef struct packed {
    seq_t seq;
    len_t len;
    logic syn;
    logic fin;
  } seg_t;

  typedef struct packed {
    logic accepted;
    seq_t trimmed_seq;
    len_t trimmed_length;
    logic syn_kept;
    logic fin_kept;
    len_t payload_skip;
    seq_t expected_next;
  } result_t;

endpackage

### rtl/core/trwc_eval.sv
// ----------------------------------------------------------------------------
// trwc_eval
// Window acceptability test, front and end trim, and expected sequence
// advance for one segment, all in modulo 2^32 sequence space.
// ----------------------------------------------------------------------------
module trwc_eval (
  input  trwc_pkg::seg_t    seg,
  input  trwc_pkg::seq_t    expected,
  input  trwc_pkg::win_t    win_len,
  output trwc_pkg::result_t result
);
  import trwc_pkg::*;

  seq_t win32;
  seq_t off_first;
  seq_t off_end;
  seq_t off_last;
  seq_t step_len;
  seq_t acked;
  seq_t beyond;
  logic first_in;
  logic last_in;
  logic win_zero;
  logic len_zero;
  logic acc;
  logic acked_nz;
  logic beyond_nz;

  assign win32     = {1'b0, win_len};
  assign off_first = seg.seq - expected;
  assign off_end   = seg.seq + {{(SEQ_W-LEN_W){1'b0}}, seg.len} - expected;
  assign off_last  = off_end - 32'd1;
  assign first_in  = off_first < win32;
  assign last_in   = off_last < win32;
  assign win_zero  = (win_len == '0);
  assign len_zero  = (seg.len == '0);

  always_comb begin
    if (win_zero) begin
      acc = len_zero && (seg.seq == expected);
    end else begin
      acc = first_in || (!len_zero && last_in);
    end
  end

  // advance by the distance to the segment end, capped at the window
  assign step_len  = (off_end > win32) ? win32 : off_end;
  assign acked     = (!len_zero && !first_in) ? (expected - seg.seq) : '0;
  assign beyond    = (!len_zero && !last_in) ? (off_end - win32) : '0;
  assign acked_nz  = (acked != '0);
  assign beyond_nz = (beyond != '0);

  always_comb begin
    if (acc) begin
      result.accepted       = 1'b1;
      result.trimmed_seq    = seg.seq + acked;
      result.trimmed_length = seg.len - acked[LEN_W-1:0] - beyond[LEN_W-1:0];
      // a SYN in the acknowledged front takes one sequence slot that is not payload
      result.syn_kept       = seg.syn && !acked_nz;
      result.fin_kept       = seg.fin && !beyond_nz;
      result.payload_skip   = acked[LEN_W-1:0]
                              - {{(LEN_W-1){1'b0}}, (seg.syn && acked_nz)};
      result.expected_next  = expected + step_len;
    end else begin
      result.accepted       = 1'b0;
      result.trimmed_seq    = '0;
      result.trimmed_length = '0;
      result.syn_kept       = 1'b0;
      result.fin_kept       = 1'b0;
      result.payload_skip   = '0;
      result.expected_next  = expected;
    end
  end

endmodule

### rtl/core/tcp_receive_window_checker_unit.sv
// ----------------------------------------------------------------------------
// tcp_receive_window_checker_unit
// Receive-side TCP segment acceptability check and trim to the window.
// ----------------------------------------------------------------------------
// The unit takes one segment word per cycle and returns one result word per
// segment; each segment passes the input register, then the result register.
// Throughput is one word per clock unless the output stalls; the clock is set
// by the loop from the expected sequence register through the window compares
// and the advance adder back into that register. A stalled output holds the
// result register and, once the input register is also full, drops in_ready.
// Write the window size and the start sequence only while no segment is in
// flight; a start sequence write also loads the expected sequence.
module tcp_receive_window_checker_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  trwc_pkg::seq_t       segment_seq,
  input  trwc_pkg::len_t       segment_length,
  input  logic                 syn_flag,
  input  logic                 fin_flag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 accepted,
  output trwc_pkg::seq_t       trimmed_seq,
  output trwc_pkg::len_t       trimmed_length,
  output logic                 syn_kept,
  output logic                 fin_kept,
  output trwc_pkg::len_t       payload_skip,
  output trwc_pkg::seq_t       expected_next,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  trwc_pkg::cfg_idx_t   cfg_index,
  input  logic [trwc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import trwc_pkg::*;

  win_t    win_len;
  seq_t    recv_expected;
  logic    stage_valid;
  seg_t    stage_seg;
  result_t calc;
  result_t res;
  logic    advance;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !stage_valid || advance;

  trwc_eval u_eval (
    .seg         (stage_seg),
    .expected    (recv_expected),
    .win_len     (win_len),
    .result      (calc)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_seg.seq <= segment_seq;
      stage_seg.len <= segment_length;
      stage_seg.syn <= syn_flag;
      stage_seg.fin <= fin_flag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
    if (advance && stage_valid) begin
      res <= calc;
    end
  end

  // configuration and expected sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len       <= '0;
      recv_expected <= '0;
    end else begin
      if (advance && stage_valid) begin
        recv_expected <= calc.expected_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_SIZE:    win_len       <= cfg_data[WIN_W-1:0];
          REG_START_SEQUENCE: recv_expected <= cfg_data[SEQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign accepted       = res.accepted;
  assign trimmed_seq    = res.trimmed_seq;
  assign trimmed_length = res.trimmed_length;
  assign syn_kept       = res.syn_kept;
  assign fin_kept       = res.fin_kept;
  assign payload_skip   = res.payload_skip;
  assign expected_next  = res.expected_next;

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid && out_valid && !out_ready))
    else $error("in_ready low without a full pipeline");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (trimmed_length == '0 && payload_skip == '0
      && !syn_kept && !fin_kept && trimmed_seq == '0))
    else $error("rejected segment carries trim data");

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid))
    else $error("result word without a staged segment");

endmodule
